@@ hdl/thread_hashed_branch_target_buffer_assert.svh @@
// Assertion macros for the thread-hashed branch target buffer.
// Clocked on clk, reset by arst_n, both taken from the including module.
`ifndef THREAD_HASHED_BRANCH_TARGET_BUFFER_ASSERT_SVH
`define THREAD_HASHED_BRANCH_TARGET_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define THBTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define THBTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define THBTB_ASSERT(lbl, prop, msg)
`define THBTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/thbtb_pkg.sv @@
// Shared constants and types of the thread-hashed branch target buffer.
// No dependencies.
package thbtb_pkg;

	localparam int ENTRIES_DEF  = 1024;
	localparam int TAG_BITS_DEF = 16;
	localparam int INST_SHIFT   = 2;
	localparam int THREADS      = 4;
	localparam int ADDR_BITS    = 48;

	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 8;
	localparam int TID_W      = 2;
	localparam int EPOCH_BITS = 3;

	// floor(log2(THREADS))
	localparam int THREAD_LOG = $clog2(THREADS + 1) - 1;

	localparam int ADDR_KEEP = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_KEEP);

	typedef enum logic [1:0] {
		OP_LOOKUP   = 2'd0,
		OP_FULL_UPD = 2'd1,
		OP_TGT_UPD  = 2'd2,
		OP_FLUSH    = 2'd3
	} op_t;

	// sweep status seen by the pipeline
	typedef struct packed {
		logic                  busy;
		logic [EPOCH_BITS-1:0] epoch;
	} sweep_t;

endpackage

@@ hdl/thbtb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module thbtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/thbtb_sweep.sv @@
// Flush epoch counter and clearing sweep of the tag memory.
// Depends on thbtb_pkg and the assertion header.
`include "thread_hashed_branch_target_buffer_assert.svh"
module thbtb_sweep #(
	parameter int ENTRIES = thbtb_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       flush_go,
	output thbtb_pkg::sweep_t          st,
	output logic [$clog2(ENTRIES)-1:0] addr
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic                            busy_q;
	logic [thbtb_pkg::EPOCH_BITS-1:0] epoch_q;
	logic [IDX_W-1:0]                addr_q;

	// flush bumps the epoch; on wrap every entry is cleared before reuse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			epoch_q <= '0;
			addr_q  <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + 1'b1;
			if (addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end else if (flush_go) begin
			if (epoch_q == '1) begin
				busy_q  <= 1'b1;
				epoch_q <= '0;
				addr_q  <= '0;
			end else begin
				epoch_q <= epoch_q + 1'b1;
			end
		end
	end

	assign st.busy  = busy_q;
	assign st.epoch = epoch_q;
	assign addr     = addr_q;

	`THBTB_ASSERT(a_sweep_step, busy_q && addr_q != '1 |=> busy_q && addr_q == $past(addr_q) + 1'b1, "sweep skipped an entry")
	`THBTB_ASSERT(a_sweep_done, busy_q && addr_q == '1 |=> !busy_q, "sweep overran")
	`THBTB_ASSERT(a_sweep_wrap, !busy_q && flush_go && epoch_q == '1 |=> busy_q && addr_q == '0 && epoch_q == '0, "epoch wrap did not start sweep")

endmodule

@@ hdl/thread_hashed_branch_target_buffer.sv @@
// Thread-hashed direct-mapped branch target buffer, top level.
// Words pass through stage 1, stage 2 and the output register to the result word;
// one word per cycle sustained while out_stall is low and no sweep runs.
// After reset, and after every 8th flush (epoch wrap), a sweep clears the tag memory
// and no input word is taken. Depends on thbtb_pkg, thbtb_ram, thbtb_sweep.
`include "thread_hashed_branch_target_buffer_assert.svh"
module thread_hashed_branch_target_buffer #(
	parameter int ENTRIES  = thbtb_pkg::ENTRIES_DEF,
	parameter int TAG_BITS = thbtb_pkg::TAG_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [thbtb_pkg::ADDR_W-1:0]    pc,
	input  logic [thbtb_pkg::TID_W-1:0]     thread_id,
	input  logic [thbtb_pkg::ADDR_W-1:0]    new_target,
	input  logic [thbtb_pkg::ADDR_W-1:0]    new_branch_pc,
	input  logic [thbtb_pkg::SIZE_W-1:0]    new_block_size,
	input  logic [thbtb_pkg::ADDR_W-1:0]    new_fallthrough,
	input  logic                            new_uncond,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [thbtb_pkg::ADDR_W-1:0]    target,
	output logic [thbtb_pkg::ADDR_W-1:0]    branch_pc,
	output logic [thbtb_pkg::SIZE_W-1:0]    block_size,
	output logic [thbtb_pkg::ADDR_W-1:0]    fallthrough,
	output logic                            uncond
);

	localparam int AW    = thbtb_pkg::ADDR_W;
	localparam int SW    = thbtb_pkg::SIZE_W;
	localparam int TW    = thbtb_pkg::TID_W;
	localparam int EW    = thbtb_pkg::EPOCH_BITS;
	localparam int IDX_W = $clog2(ENTRIES);

	// thread id lands in the top index bits
	localparam int HASH_SHIFT = (IDX_W >= thbtb_pkg::THREAD_LOG) ?
		IDX_W - thbtb_pkg::THREAD_LOG : 0;
	localparam int TAG_SHIFT = thbtb_pkg::INST_SHIFT + IDX_W;

	// tag memory word: {valid, epoch, thread, tag, target}
	localparam int M_TAG_LO = AW;
	localparam int M_TID_LO = AW + TAG_BITS;
	localparam int M_EP_LO  = AW + TAG_BITS + TW;
	localparam int META_W   = AW + TAG_BITS + TW + EW + 1;

	// payload memory word: {branch_pc, block_size, fallthrough, uncond}
	localparam int P_FT_LO  = 1;
	localparam int P_BSZ_LO = 1 + AW;
	localparam int P_BPC_LO = 1 + AW + SW;
	localparam int PAY_W    = 1 + AW + SW + AW;

	// ---------------------------------------------------------------
	// Index and tag from the incoming word
	// ---------------------------------------------------------------
	logic [AW-1:0]       pc_m;
	logic [AW-1:0]       pc_ix;
	logic [AW-1:0]       pc_tg;
	logic [IDX_W-1:0]    tid_hash;
	logic [IDX_W-1:0]    idx_in;
	logic [TAG_BITS-1:0] tag_in;

	always_comb begin
		pc_m     = pc & thbtb_pkg::ADDR_MASK;
		pc_ix    = pc_m >> thbtb_pkg::INST_SHIFT;
		pc_tg    = pc_m >> TAG_SHIFT;
		tid_hash = IDX_W'(thread_id) << HASH_SHIFT;
		idx_in   = pc_ix[IDX_W-1:0] ^ tid_hash;
		tag_in   = pc_tg[TAG_BITS-1:0];
	end

	// ---------------------------------------------------------------
	// Flow control: each stage moves when the one ahead frees up
	// ---------------------------------------------------------------
	thbtb_pkg::sweep_t sweep_st;
	logic [IDX_W-1:0]  sweep_addr;

	logic             valid_s1;
	thbtb_pkg::op_t   op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [TW-1:0]    tid_s1;
	logic [AW-1:0]    tgt_s1;
	logic [AW-1:0]    bpc_s1;
	logic [SW-1:0]    bsz_s1;
	logic [AW-1:0]    ft_s1;
	logic             unc_s1;

	logic             valid_s2;
	thbtb_pkg::op_t   op_s2;
	logic [TAG_BITS-1:0] tag_s2;
	logic [TW-1:0]    tid_s2;

	logic out_valid_q;
	logic out_en;
	logic s2_en;
	logic s1_go;
	logic in_acc;
	logic flush_go;

	assign out_en   = !out_valid_q || !out_stall;
	assign s2_en    = !valid_s2 || out_en;
	// stage 1 holds its word while the sweep owns the tag memory
	assign s1_go    = valid_s1 && s2_en && !sweep_st.busy;
	assign in_stall = sweep_st.busy || (valid_s1 && !s1_go);
	assign in_acc   = in_valid && !in_stall;
	assign flush_go = s1_go && (op_s1 == thbtb_pkg::OP_FLUSH);

	// ---------------------------------------------------------------
	// Stage 1: registered request, drives both memories
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= thbtb_pkg::op_t'(opcode);
			idx_s1 <= idx_in;
			tag_s1 <= tag_in;
			tid_s1 <= thread_id;
			tgt_s1 <= new_target & thbtb_pkg::ADDR_MASK;
			bpc_s1 <= new_branch_pc & thbtb_pkg::ADDR_MASK;
			bsz_s1 <= new_block_size;
			ft_s1  <= new_fallthrough & thbtb_pkg::ADDR_MASK;
			unc_s1 <= new_uncond;
		end
	end

	// Tag memory: both kinds of update write it, the sweep clears it.
	// Valid means the stored valid bit is set and its epoch is current,
	// so a flush needs no sweep until the epoch wraps.
	logic              meta_we;
	logic [IDX_W-1:0]  meta_waddr;
	logic [META_W-1:0] meta_wdata;
	logic              meta_re;
	logic [META_W-1:0] meta_rd;
	logic              upd_s1;

	assign upd_s1     = (op_s1 == thbtb_pkg::OP_FULL_UPD) ||
		(op_s1 == thbtb_pkg::OP_TGT_UPD);
	assign meta_we    = sweep_st.busy || (s1_go && upd_s1);
	assign meta_waddr = sweep_st.busy ? sweep_addr : idx_s1;
	assign meta_wdata = sweep_st.busy ? '0 :
		{1'b1, sweep_st.epoch, tid_s1, tag_s1, tgt_s1};
	assign meta_re    = s1_go && (op_s1 == thbtb_pkg::OP_LOOKUP);

	thbtb_ram #(
		.WIDTH (META_W),
		.DEPTH (ENTRIES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (idx_s1),
		.rdata (meta_rd)
	);

	// Payload memory: full updates only; never cleared, a target-only
	// update leaves these fields as they were.
	logic             pay_we;
	logic [PAY_W-1:0] pay_rd;

	assign pay_we = s1_go && (op_s1 == thbtb_pkg::OP_FULL_UPD);

	thbtb_ram #(
		.WIDTH (PAY_W),
		.DEPTH (ENTRIES)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (idx_s1),
		.wdata ({bpc_s1, bsz_s1, ft_s1, unc_s1}),
		.re    (meta_re),
		.raddr (idx_s1),
		.rdata (pay_rd)
	);

	thbtb_sweep #(
		.ENTRIES (ENTRIES)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush_go (flush_go),
		.st       (sweep_st),
		.addr     (sweep_addr)
	);

	// ---------------------------------------------------------------
	// Stage 2: memory data arrives; read enables stay low while it
	// waits, so the read words hold.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= s1_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && s1_go) begin
			op_s2  <= op_s1;
			tag_s2 <= tag_s1;
			tid_s2 <= tid_s1;
		end
	end

	logic hit_nxt;

	// A write behind a lookup happens at the edge that captures the
	// lookup's result, so the lookup sees the old entry, as it should.
	always_comb begin
		hit_nxt = (op_s2 == thbtb_pkg::OP_LOOKUP) &&
			meta_rd[META_W-1] &&
			(meta_rd[M_EP_LO +: EW] == sweep_st.epoch) &&
			(meta_rd[M_TAG_LO +: TAG_BITS] == tag_s2) &&
			(meta_rd[M_TID_LO +: TW] == tid_s2);
	end

	// ---------------------------------------------------------------
	// Output register: misses, updates and flushes give all zero
	// ---------------------------------------------------------------
	logic          hit_q;
	logic [AW-1:0] target_q;
	logic [AW-1:0] branch_pc_q;
	logic [SW-1:0] block_size_q;
	logic [AW-1:0] fallthrough_q;
	logic          uncond_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			hit_q         <= hit_nxt;
			target_q      <= hit_nxt ? meta_rd[AW-1:0] : '0;
			branch_pc_q   <= hit_nxt ? pay_rd[P_BPC_LO +: AW] : '0;
			block_size_q  <= hit_nxt ? pay_rd[P_BSZ_LO +: SW] : '0;
			fallthrough_q <= hit_nxt ? pay_rd[P_FT_LO +: AW] : '0;
			uncond_q      <= hit_nxt && pay_rd[0];
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign target      = target_q;
	assign branch_pc   = branch_pc_q;
	assign block_size  = block_size_q;
	assign fallthrough = fallthrough_q;
	assign uncond      = uncond_q;

	`THBTB_ASSERT_ALWAYS(a_miss_zero, out_valid_q && !hit_q |-> target_q == '0 && branch_pc_q == '0 && block_size_q == '0 && fallthrough_q == '0 && !uncond_q, "miss word not zero")
	`THBTB_ASSERT(a_meta_we_src, meta_we && !sweep_st.busy |-> valid_s1 && (op_s1 == thbtb_pkg::OP_FULL_UPD || op_s1 == thbtb_pkg::OP_TGT_UPD), "tag memory write without update")
	`THBTB_ASSERT(a_s2_hold, valid_s2 && !s2_en |=> valid_s2 && $stable(tag_s2) && $stable(meta_rd) && $stable(pay_rd), "stage 2 lost its read data")

endmodule
